@@ design/thruster_pwm_mixer_macros.svh @@
`ifndef THRUSTER_PWM_MIXER_MACROS_SVH
`define THRUSTER_PWM_MIXER_MACROS_SVH

// same-cycle implication, checked on every clock outside reset
`define TPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tpm assertion failed");

// next-cycle implication, checked on every clock outside reset
`define TPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tpm assertion failed");

`endif

@@ design/tpm_pkg.sv @@
package tpm_pkg;

  localparam int PulseW = 12;
  localparam int ValueW = 10;
  localparam int CorrW  = 11;
  localparam int WideW  = 14;

  localparam logic [1:0] OP_DEPTH_DRIVE      = 2'd0;
  localparam logic [1:0] OP_FORWARD_DRIVE    = 2'd1;
  localparam logic [1:0] OP_YAW_CORRECTION   = 2'd2;
  localparam logic [1:0] OP_DEPTH_CORRECTION = 2'd3;

  localparam logic [1:0] CFG_BASELINE = 2'd0;
  localparam logic [1:0] CFG_OFFSET   = 2'd1;
  localparam logic [1:0] CFG_KICK     = 2'd2;

  localparam logic [PulseW-1:0] RESET_BASELINE = 12'd1500;
  localparam logic [7:0]        RESET_OFFSET   = 8'd25;
  localparam logic [7:0]        RESET_KICK     = 8'd29;
  localparam logic [PulseW-1:0] PULSE_MAX      = 12'd4095;

  // floor(x/30) = floor(floor(x/2)/15); bias makes the operand nonnegative
  localparam logic signed [16:0] REMAP_BIAS   = 17'sd31605;
  localparam logic signed [WideW-1:0] REMAP_BIAS_Q = 14'sd2107;
  localparam logic [16:0]        REMAP_RECIP  = 17'd69906;

  typedef struct packed {
    logic [PulseW-1:0]       depth_drive;
    logic [PulseW-1:0]       forward_drive;
    logic signed [CorrW-1:0] depth_correction;
    logic signed [CorrW-1:0] yaw_correction;
  } tpm_state_t;

  function automatic logic [PulseW-1:0] sat_pulse(input logic signed [WideW-1:0] x);
    logic [PulseW-1:0] r;
    priority if (x < 14'sd0) r = '0;
    else if (x > $signed({2'b00, PULSE_MAX})) r = PULSE_MAX;
    else r = x[PulseW-1:0];
    return r;
  endfunction

  function automatic logic [PulseW-1:0] drive_value(
    input logic signed [ValueW-1:0] v,
    input logic [PulseW-1:0]        b,
    input logic [7:0]               o
  );
    logic signed [WideW-1:0] v14;
    logic signed [WideW-1:0] b14;
    logic signed [WideW-1:0] o14;
    logic [PulseW-1:0]       r;
    v14 = {{(WideW-ValueW){v[ValueW-1]}}, v};
    b14 = $signed({2'b00, b});
    o14 = $signed({6'b000000, o});
    priority if (v == '0) r = b;
    else if (v < 10'sd0) r = sat_pulse(b14 - o14 + v14);
    else r = sat_pulse(b14 + o14 + v14);
    return r;
  endfunction

endpackage

@@ design/tpm_state.sv @@
module tpm_state (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [1:0]          op,
  input  logic signed [9:0]   value,
  input  logic [11:0]         baseline,
  input  logic [7:0]          offset,
  input  logic [7:0]          kick,
  output tpm_pkg::tpm_state_t st
);
  import tpm_pkg::*;

  tpm_state_t              st_next;
  logic signed [CorrW-1:0] v11;
  logic signed [CorrW-1:0] o11;
  logic signed [CorrW-1:0] k11;

  assign v11 = {value[ValueW-1], value};
  assign o11 = $signed({3'b000, offset});
  assign k11 = $signed({3'b000, kick});

  always_comb begin
    st_next = st;
    unique case (op)
      OP_DEPTH_DRIVE: begin
        st_next.depth_drive = drive_value(value, baseline, offset);
      end
      OP_FORWARD_DRIVE: begin
        st_next.forward_drive = drive_value(value, baseline, offset);
      end
      OP_YAW_CORRECTION: begin
        // kick only while forward drive sits at baseline
        if (st.forward_drive == baseline) begin
          priority if (v11 > 11'sd0) st_next.yaw_correction = v11 + k11;
          else if (v11 < 11'sd0) st_next.yaw_correction = v11 - k11;
          else st_next.yaw_correction = '0;
        end else begin
          st_next.yaw_correction = v11;
        end
      end
      OP_DEPTH_CORRECTION: begin
        priority if (v11 > 11'sd1) st_next.depth_correction = o11 + v11;
        else if (v11 < -11'sd1) st_next.depth_correction = v11 - o11;
        else st_next.depth_correction = '0;
      end
      default: st_next = st;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.depth_drive      <= RESET_BASELINE;
      st.forward_drive    <= RESET_BASELINE;
      st.depth_correction <= '0;
      st.yaw_correction   <= '0;
    end else if (load) begin
      st <= st_next;
    end
  end

endmodule

@@ design/tpm_remap.sv @@
module tpm_remap (
  input  logic               clk,
  input  logic               en,
  input  logic signed [13:0] total,
  input  logic [11:0]        baseline,
  output logic [11:0]        pulse
);
  import tpm_pkg::*;

  logic signed [WideW-1:0] diff;
  logic signed [17:0]      diff18;
  logic signed [17:0]      scaled;
  logic signed [17:0]      half;
  logic signed [17:0]      biased;
  logic [15:0]             y;
  logic [32:0]             prod;
  logic [12:0]             q;
  logic signed [WideW-1:0] rr;

  assign diff   = total - $signed({2'b00, baseline});
  assign diff18 = {{(18-WideW){diff[WideW-1]}}, diff};
  // times 13 as shift and add, then floor of half
  assign scaled = (diff18 <<< 3) + (diff18 <<< 2) + diff18;
  assign half   = scaled >>> 1;
  assign biased = half + {REMAP_BIAS[16], REMAP_BIAS};

  // divide by 15 through a reciprocal, exact for 16 bit operands
  assign prod = {17'b0, y} * {16'b0, REMAP_RECIP};

  assign rr = $signed({2'b00, baseline}) + $signed({1'b0, q}) - REMAP_BIAS_Q;

  always_ff @(posedge clk) begin
    if (en) begin
      y     <= biased[15:0];
      q     <= prod[32:20];
      pulse <= sat_pulse(rr);
    end
  end

endmodule

@@ design/thruster_pwm_mixer.sv @@
// thruster pulse mixer
// input channel: in_valid/in_stall with opcode and a signed value; each item
// updates one stored drive or correction and yields one item of four pulses
// on the output channel out_valid/out_stall (depth, rear right, left, right).
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
// baseline, 1 deadband offset, 2 yaw kick, others ignored. cfg_ready is
// always high; write only while no item is in flight.
// throughput: one item per cycle while the output is not stalled; the
// state update is its own register stage, and the rear-right remap (times
// 13, reciprocal divide by 30) spreads over the following three register
// stages. a stalled output holds its item and freezes the whole pipeline, and
// in_stall is raised while the output is full and stalled.
// reset: registers go to baseline 1500, offset 25, kick 29, drives at
// baseline, corrections zero, pipeline empty.
`include "thruster_pwm_mixer_macros.svh"

module thruster_pwm_mixer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic signed [9:0] value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [11:0]       depth_pulse,
  output logic [11:0]       rear_right_pulse,
  output logic [11:0]       left_pulse,
  output logic [11:0]       right_pulse,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [11:0]       cfg_data
);
  import tpm_pkg::*;

  logic [PulseW-1:0] baseline_us;
  logic [7:0]        deadband_offset;
  logic [7:0]        yaw_kick;

  logic              en;
  logic              v1, v2, v3, v4;
  logic [1:0]        s1_op;
  logic signed [9:0] s1_value;
  tpm_state_t        st;

  logic signed [WideW-1:0] total;
  logic signed [WideW-1:0] fwd14;
  logic signed [WideW-1:0] yaw14;
  logic [PulseW-1:0] s3_depth, s3_left, s3_right;
  logic [PulseW-1:0] s4_depth, s4_left, s4_right;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_us     <= RESET_BASELINE;
      deadband_offset <= RESET_OFFSET;
      yaw_kick        <= RESET_KICK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASELINE: baseline_us     <= cfg_data;
        CFG_OFFSET:   deadband_offset <= cfg_data[7:0];
        CFG_KICK:     yaw_kick        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op    <= opcode;
      s1_value <= value;
    end
  end

  // stored state doubles as the stage after the input register
  tpm_state u_state (
    .clk      (clk),
    .rst      (rst),
    .load     (en && v1),
    .op       (s1_op),
    .value    (s1_value),
    .baseline (baseline_us),
    .offset   (deadband_offset),
    .kick     (yaw_kick),
    .st       (st)
  );

  assign total = $signed({2'b00, st.depth_drive})
               + {{(WideW-CorrW){st.depth_correction[CorrW-1]}}, st.depth_correction};
  assign fwd14 = $signed({2'b00, st.forward_drive});
  assign yaw14 = {{(WideW-CorrW){st.yaw_correction[CorrW-1]}}, st.yaw_correction};

  always_ff @(posedge clk) begin
    if (en) begin
      s3_depth    <= sat_pulse(total);
      s3_left     <= sat_pulse(fwd14 - yaw14);
      s3_right    <= sat_pulse(fwd14 + yaw14);
      s4_depth    <= s3_depth;
      s4_left     <= s3_left;
      s4_right    <= s3_right;
      depth_pulse <= s4_depth;
      left_pulse  <= s4_left;
      right_pulse <= s4_right;
    end
  end

  tpm_remap u_remap (
    .clk      (clk),
    .en       (en),
    .total    (total),
    .baseline (baseline_us),
    .pulse    (rear_right_pulse)
  );

  `TPM_ASSERT_NOW(a_stall_only_on_backpressure, in_stall, out_valid && out_stall)
  `TPM_ASSERT_NEXT(a_last_stage_reaches_output, en && v4, out_valid)
  `TPM_ASSERT_NEXT(a_small_depth_corr_is_zero,
    en && v1 && s1_op == OP_DEPTH_CORRECTION && s1_value == 10'sd0,
    st.depth_correction == 11'sd0)

endmodule

@@ dv/thruster_pwm_mixer_test.sv @@
module thruster_pwm_mixer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tpm_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;  // unmapped register index
  localparam int LATENCY = 4;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 112;

  typedef struct packed {
    logic [11:0] depth;
    logic [11:0] rear_right;
    logic [11:0] left;
    logic [11:0] right;
  } pulse_set_t;

  typedef struct {
    logic [1:0]        op;
    logic signed [9:0] val;
    bit                typed;
    pulse_set_t        want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        opcode;
  logic signed [9:0] value;
  logic              out_valid;
  logic              out_stall;
  logic [11:0]       depth_pulse;
  logic [11:0]       rear_right_pulse;
  logic [11:0]       left_pulse;
  logic [11:0]       right_pulse;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [11:0]       cfg_data;

  thruster_pwm_mixer dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mixer registers and state as the block should hold them
  logic [11:0]        base_q;
  logic [7:0]         offs_q;
  logic [7:0]         kick_q;
  logic [11:0]        depth_drv_q;
  logic [11:0]        fwd_drv_q;
  logic signed [10:0] depth_corr_q;
  logic signed [10:0] yaw_corr_q;

  pulse_set_t pulses_due[$];
  dir_row_t   directed_rows[$];
  int         errors = 0;
  int         burst_left = 0;

  function automatic logic [11:0] clamp_pulse(int x);
    if (x < 0) return 12'd0;
    if (x > 4095) return 12'd4095;
    return x[11:0];
  endfunction

  function automatic int floor_div30(int n);
    if (n >= 0) return n / 30;
    return -((-n + 29) / 30);
  endfunction

  function automatic logic [11:0] drive_level(int v);
    int b;
    int o;
    b = int'(base_q);
    o = int'(offs_q);
    if (v == 0) return base_q;
    if (v < 0) return clamp_pulse(b - o + v);
    return clamp_pulse(b + o + v);
  endfunction

  function automatic pulse_set_t mix_item(logic [1:0] op, logic signed [9:0] val);
    pulse_set_t p;
    int v;
    int b;
    int o;
    int k;
    int total;
    int fwd;
    int yaw;
    v = val;
    b = int'(base_q);
    o = int'(offs_q);
    k = int'(kick_q);
    case (op)
      OP_DEPTH_DRIVE: depth_drv_q = drive_level(v);
      OP_FORWARD_DRIVE: fwd_drv_q = drive_level(v);
      OP_YAW_CORRECTION: begin
        // kick only applies while forward drive sits at baseline
        if (fwd_drv_q == base_q) begin
          if (v >= 1) yaw_corr_q = 11'(v + k);
          else if (v <= -1) yaw_corr_q = 11'(v - k);
          else yaw_corr_q = '0;
        end else begin
          yaw_corr_q = 11'(v);
        end
      end
      default: begin
        if (v > 1) depth_corr_q = 11'(o + v);
        else if (v < -1) depth_corr_q = 11'(v - o);
        else depth_corr_q = '0;
      end
    endcase
    total = int'(depth_drv_q) + int'(depth_corr_q);
    fwd = int'(fwd_drv_q);
    yaw = int'(yaw_corr_q);
    p.depth = clamp_pulse(total);
    p.rear_right = clamp_pulse(b + floor_div30((total - b) * 13));
    p.left = clamp_pulse(fwd - yaw);
    p.right = clamp_pulse(fwd + yaw);
    return p;
  endfunction

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (want !== got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  function automatic logic signed [9:0] pick_value();
    int t;
    case ($urandom_range(0, 7))
      0: t = 0;
      1: t = int'($urandom_range(0, 4)) - 2;
      2: t = $urandom_range(0, 1) ? 511 : -512;
      default: t = int'($urandom_range(0, 1023)) - 512;
    endcase
    return t[9:0];
  endfunction

  task automatic add_row(logic [1:0] op, int v, bit typed, pulse_set_t want);
    dir_row_t r;
    r.op = op;
    r.val = v[9:0];
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  task automatic send_item(logic [1:0] op, logic signed [9:0] val, bit typed,
                           pulse_set_t want);
    pulse_set_t calc;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        opcode <= 2'($urandom);
        value <= 10'($urandom);
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    opcode <= op;
    value <= val;
    do @(posedge clk); while (in_stall);
    calc = mix_item(op, val);
    pulses_due.push_back(typed ? want : calc);
    @(negedge clk);
  endtask

  task automatic send_random();
    // forward drive back to baseline followed by yaw reaches the kick path
    if ($urandom_range(0, 9) == 0) begin
      send_item(OP_FORWARD_DRIVE, '0, 1'b0, '0);
      send_item(OP_YAW_CORRECTION, pick_value(), 1'b0, '0);
    end else begin
      send_item(2'($urandom_range(0, 3)), pick_value(), 1'b0, '0);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASELINE: base_q = d;
      CFG_OFFSET: offs_q = d[7:0];
      CFG_KICK: kick_q = d[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(logic [11:0] b, logic [11:0] o, logic [11:0] k);
    in_valid <= 1'b0;
    while (pulses_due.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
    write_reg(CFG_BASELINE, b);
    write_reg(CFG_OFFSET, o);
    write_reg(CFG_KICK, k);
    write_reg(CFG_SPARE, 12'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = '0;
    value = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    base_q = RESET_BASELINE;
    offs_q = RESET_OFFSET;
    kick_q = RESET_KICK;
    depth_drv_q = RESET_BASELINE;
    fwd_drv_q = RESET_BASELINE;
    depth_corr_q = '0;
    yaw_corr_q = '0;

    // depth, rear right, left, right
    add_row(OP_DEPTH_DRIVE, 0, 1'b1, {12'd1500, 12'd1500, 12'd1500, 12'd1500});
    add_row(OP_YAW_CORRECTION, 1, 1'b1, {12'd1500, 12'd1500, 12'd1470, 12'd1530});
    add_row(OP_YAW_CORRECTION, -1, 1'b1, {12'd1500, 12'd1500, 12'd1530, 12'd1470});
    add_row(OP_YAW_CORRECTION, 0, 1'b1, {12'd1500, 12'd1500, 12'd1500, 12'd1500});
    add_row(OP_DEPTH_DRIVE, 511, 1'b1, {12'd2036, 12'd1732, 12'd1500, 12'd1500});
    add_row(OP_DEPTH_DRIVE, -512, 1'b1, {12'd963, 12'd1267, 12'd1500, 12'd1500});
    // depth correction dead zone edges
    add_row(OP_DEPTH_CORRECTION, 1, 1'b0, '0);
    add_row(OP_DEPTH_CORRECTION, -1, 1'b0, '0);
    add_row(OP_DEPTH_CORRECTION, 2, 1'b0, '0);
    add_row(OP_DEPTH_CORRECTION, -2, 1'b0, '0);
    add_row(OP_DEPTH_CORRECTION, 511, 1'b0, '0);
    add_row(OP_DEPTH_CORRECTION, -512, 1'b0, '0);
    add_row(OP_DEPTH_CORRECTION, 0, 1'b0, '0);
    // yaw off baseline takes the value as is
    add_row(OP_FORWARD_DRIVE, 511, 1'b0, '0);
    add_row(OP_YAW_CORRECTION, 511, 1'b0, '0);
    add_row(OP_FORWARD_DRIVE, -512, 1'b0, '0);
    add_row(OP_YAW_CORRECTION, -512, 1'b0, '0);
    add_row(OP_FORWARD_DRIVE, 1, 1'b0, '0);
    add_row(OP_FORWARD_DRIVE, -1, 1'b0, '0);
    add_row(OP_YAW_CORRECTION, 3, 1'b0, '0);
    add_row(OP_FORWARD_DRIVE, 0, 1'b0, '0);
    add_row(OP_YAW_CORRECTION, 5, 1'b0, '0);
    add_row(OP_DEPTH_DRIVE, 1, 1'b0, '0);
    add_row(OP_DEPTH_DRIVE, -1, 1'b0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].val, directed_rows[i].typed,
                directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: set_regs(12'd0, 12'd255, 12'd255);
        2: set_regs(12'd4095, 12'd255, 12'd0);
        3: set_regs(12'd4095, 12'd0, 12'd255);
        4: set_regs(12'd0, 12'd0, 12'd0);
        5: set_regs(12'd500, 12'd25, 12'd29);
        // upper data bits are dropped for the 8 bit registers
        6: set_regs(12'd2500, 12'hfff, 12'hf00);
        default: set_regs(12'($urandom_range(500, 2500)), 12'($urandom), 12'($urandom));
      endcase
      repeat (ITEMS_PER_PHASE) send_random();
    end

    in_valid <= 1'b0;
    while (pulses_due.size() != 0) @(negedge clk);
    repeat (LATENCY * 3) @(posedge clk);
    if (errors == 0)
      $display("thruster_pwm_mixer_test: done, clean");
    else
      $display("thruster_pwm_mixer_test: done, errors");
    $finish;
  end

  // receiver: long clean stretches, short hard stalls and choppy runs
  initial begin
    int mode;
    int n;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: n = $urandom_range(40, 120);
        1: n = $urandom_range(1, 6);
        default: n = $urandom_range(10, 30);
      endcase
      repeat (n) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'b1;
          default: out_stall <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  always @(posedge clk) begin
    pulse_set_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pulses_due.size() == 0) begin
        errors++;
        $error("unexpected item: depth %0d rear_right %0d left %0d right %0d",
               depth_pulse, rear_right_pulse, left_pulse, right_pulse);
      end else begin
        want = pulses_due.pop_front();
        check_field("depth_pulse", want.depth, depth_pulse);
        check_field("rear_right_pulse", want.rear_right, rear_right_pulse);
        check_field("left_pulse", want.left, left_pulse);
        check_field("right_pulse", want.right, right_pulse);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("thruster_pwm_mixer_test: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/tpm_pkg.sv
design/tpm_state.sv
design/tpm_remap.sv
design/thruster_pwm_mixer.sv
dv/thruster_pwm_mixer_test.sv
